@@ rtl/core/chs_pkg.sv @@
`timescale 1ns / 1ps
package chs_pkg;
  localparam int FUNC_W = 2;
  localparam int KEY_W = 31;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 4;
  localparam int SIZE_W = 7;
  localparam int CFG_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

  // Request handed from the top level to the divider.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  // Answer from the divider.
  typedef struct packed {
    logic         done;
    logic [8:0]   rem;
  } div_rsp_t;
endpackage

@@ rtl/core/chained_hash_set.sv @@
`timescale 1ns / 1ps
// Hash set of 31-bit keys with separate chaining over a fixed slot pool.
// Requests arrive on the s_axis channel: tdata holds the key, tuser holds
// the operation (insert, delete, search). One result leaves on m_axis per
// request with status, bucket and bucket size. The user must write the
// bucket count through cfg_we/cfg_data only while the block is idle; the
// block does not enforce this. The serial divider gives the bucket while
// the sequencer waits in S_DIV. An insert then passes through S_INS to
// S_OUT. A delete or search visits the chain through an S_READ and an
// S_CHECK state for each slot, since every step is one read of the link
// and key memories; a delete that hits then passes through S_UNLINK and
// S_FREE to unlink the slot. The next request is taken in S_IDLE, which
// follows S_OUT after the result beat; requests are taken one at a time
// and s_axis_tready is low while a request is in work.
// The result is held in an output register; while m_axis_tready is low the
// block keeps it and takes no new request.
// Synchronous reset empties every bucket and then sweeps the link memory,
// one slot a cycle, to rebuild the free list; no request is accepted
// during that sweep.
module chained_hash_set #(
  parameter int MAX_BUCKETS = 16,
  parameter int POOL_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key[30:0], zero pad
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], bucket[5:2], bucket_size[12:6], pad
);
  localparam int SW = $clog2(POOL_SLOTS + 1);
  localparam int AW = $clog2(POOL_SLOTS);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam logic [SW-1:0] NIL = SW'(POOL_SLOTS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_INS, S_READ, S_CHECK, S_UNLINK, S_FREE, S_OUT
  } state_t;

  state_t                   state;
  logic [4:0]               num_buckets;
  logic [chs_pkg::KEY_W-1:0] key;
  logic [1:0]               func;
  logic [BW-1:0]            b;
  logic [SW-1:0]            head [MAX_BUCKETS];
  logic [CW-1:0]            size [MAX_BUCKETS];
  logic [SW-1:0]            free_head;
  logic [SW-1:0]            cur;
  logic [SW-1:0]            prev;
  logic [SW-1:0]            cur_link;
  logic [SW:0]              steps;
  logic [AW-1:0]            clr;
  logic [chs_pkg::STATUS_W-1:0] status;

  logic                     link_we;
  logic [AW-1:0]            link_waddr;
  logic [SW-1:0]            link_wdata;
  logic [AW-1:0]            raddr;
  logic [SW-1:0]            link_rdata;
  logic                     key_we;
  logic [chs_pkg::KEY_W-1:0] key_rdata;

  chs_pkg::div_req_t        dreq;
  chs_pkg::div_rsp_t        drsp;
  logic [4:0]               eff;

  // Effective bucket count.
  always_comb begin
    eff = num_buckets;
    if (num_buckets == 5'd0) eff = 5'd1;
    if (32'(num_buckets) > MAX_BUCKETS) eff = 5'(MAX_BUCKETS);
  end

  assign dreq.start   = s_axis_tvalid && s_axis_tready;
  assign dreq.key     = s_axis_tdata[chs_pkg::KEY_W-1:0];
  assign dreq.divisor = eff;

  chs_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  chs_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(raddr), .rdata(link_rdata));

  chs_ram #(.WIDTH(chs_pkg::KEY_W), .DEPTH(POOL_SLOTS)) u_key (
    .clk(clk), .we(key_we), .waddr(free_head[AW-1:0]), .wdata(key),
    .raddr(raddr), .rdata(key_rdata));

  // Memory port control per state.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur[AW-1:0];
    link_wdata = free_head;
    key_we     = 1'b0;
    raddr      = cur[AW-1:0];
    case (state)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr;
        link_wdata = SW'(clr) + SW'(1);
      end
      S_DIV: raddr = free_head[AW-1:0];
      S_INS: begin
        if (free_head != NIL) begin
          link_we    = 1'b1;
          link_waddr = free_head[AW-1:0];
          link_wdata = head[b];
          key_we     = 1'b1;
        end
      end
      S_UNLINK: begin
        if (prev != NIL) begin
          link_we    = 1'b1;
          link_waddr = prev[AW-1:0];
          link_wdata = cur_link;
        end
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur[AW-1:0];
        link_wdata = free_head;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {3'd0, 7'(size[b]), 4'(b), status};

  // Sequencer with the bucket tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr         <= '0;
      free_head   <= '0;
      num_buckets <= chs_pkg::CFG_RESET;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        head[i] <= NIL;
        size[i] <= '0;
      end
    end else begin
      if (cfg_we) num_buckets <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (32'(clr) == POOL_SLOTS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            key   <= s_axis_tdata[chs_pkg::KEY_W-1:0];
            func  <= s_axis_tuser;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            b      <= BW'(drsp.rem);
            prev   <= NIL;
            cur    <= head[BW'(drsp.rem)];
            steps  <= '0;
            status <= chs_pkg::ST_ABSENT;
            state  <= (func == chs_pkg::FUNC_INSERT) ? S_INS : S_READ;
          end
        end
        S_INS: begin
          // Link read at free_head was issued in S_DIV.
          if (free_head == NIL) begin
            status <= chs_pkg::ST_FULL;
          end else begin
            head[b]   <= free_head;
            size[b]   <= size[b] + CW'(1);
            free_head <= link_rdata;
            status    <= chs_pkg::ST_DONE;
          end
          state <= S_OUT;
        end
        S_READ: begin
          if (cur == NIL || 32'(steps) >= POOL_SLOTS) state <= S_OUT;
          else state <= S_CHECK;
        end
        S_CHECK: begin
          // Memory data for slot cur is now valid.
          if (key_rdata == key) begin
            status <= chs_pkg::ST_DONE;
            cur_link <= link_rdata;
            state  <= (func == chs_pkg::FUNC_DELETE) ? S_UNLINK : S_OUT;
          end else begin
            prev  <= cur;
            cur   <= link_rdata;
            steps <= steps + (SW+1)'(1);
            state <= S_READ;
          end
        end
        S_UNLINK: begin
          if (prev == NIL) head[b] <= cur_link;
          if (size[b] != '0) size[b] <= size[b] - CW'(1);
          state <= S_FREE;
        end
        S_FREE: begin
          free_head <= cur;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/chs_ram.sv @@
`timescale 1ns / 1ps
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/chs_mod.sv @@
`timescale 1ns / 1ps
// Restoring remainder of the key by the bucket count, one bit a cycle.
module chs_mod (
  input  logic              clk,
  input  logic              rst,
  input  chs_pkg::div_req_t req,
  output chs_pkg::div_rsp_t rsp
);
  logic [chs_pkg::KEY_W-1:0] shreg;
  logic [5:0]                rem;
  logic [5:0]                dvs;
  logic [4:0]                cnt;
  logic                      busy;
  logic                      done;
  logic [5:0]                trial;

  assign trial = {rem[4:0], shreg[chs_pkg::KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        shreg <= req.key;
        rem   <= '0;
        dvs   <= {1'b0, req.divisor};
        cnt   <= 5'd0;
      end else if (busy) begin
        // Shift one key bit in and subtract when the divisor fits.
        shreg <= {shreg[chs_pkg::KEY_W-2:0], 1'b0};
        rem   <= (trial >= dvs) ? trial - dvs : trial;
        cnt   <= cnt + 5'd1;
        if (cnt == 5'(chs_pkg::KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = {3'd0, rem};
endmodule

@@ rtl/core/chs_checker.sv @@
`timescale 1ns / 1ps
module chs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  // A stalled result beat holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No request is taken while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while result pending");

  // An accepted request is never answered in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  // Status code three is never produced.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status");
endmodule

bind chained_hash_set chs_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));

@@ tb/chained_hash_set_checker.sv @@
`timescale 1ns / 1ps
module chained_hash_set_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int NBKT = 16;
  localparam int NSLOT = 64;
  localparam logic [6:0] NIL = 7'd64;

  typedef struct packed {
    logic [chs_pkg::STATUS_W-1:0] status;
    logic [chs_pkg::BUCKET_W-1:0] bucket;
    logic [chs_pkg::SIZE_W-1:0]   size;
  } answer_t;

  logic [4:0]  bucket_count;
  logic [6:0]  head_of [NBKT];
  logic [6:0]  size_of [NBKT];
  logic [30:0] key_of [NSLOT];
  logic [6:0]  link_of [NSLOT];
  logic [6:0]  free_slot;
  answer_t     answers_due [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Apply one request to the shadow table and return its answer.
  function automatic answer_t apply_request(input logic [1:0] op, input logic [30:0] key);
    int divisor;
    int b;
    logic [6:0] cur;
    logic [6:0] prev;
    logic [6:0] s;
    int steps;
    answer_t a;
    divisor = bucket_count;
    if (divisor == 0) divisor = 1;
    if (divisor > NBKT) divisor = NBKT;
    b = key % divisor;
    a.status = chs_pkg::ST_ABSENT;
    if (op == chs_pkg::FUNC_INSERT) begin
      if (free_slot >= NIL) begin
        a.status = chs_pkg::ST_FULL;
      end else begin
        s = free_slot;
        free_slot = link_of[s];
        key_of[s] = key;
        link_of[s] = head_of[b];
        head_of[b] = s;
        size_of[b]++;
        a.status = chs_pkg::ST_DONE;
      end
    end else begin
      prev = NIL;
      cur = head_of[b];
      steps = 0;
      while (cur < NIL && steps < NSLOT) begin
        if (key_of[cur] == key) begin
          a.status = chs_pkg::ST_DONE;
          if (op == chs_pkg::FUNC_DELETE) begin
            if (prev >= NIL) head_of[b] = link_of[cur];
            else link_of[prev] = link_of[cur];
            if (size_of[b] > 0) size_of[b]--;
            link_of[cur] = free_slot;
            free_slot = cur;
          end
          break;
        end
        prev = cur;
        cur = link_of[cur];
        steps++;
      end
    end
    a.bucket = b[3:0];
    a.size = size_of[b];
    return a;
  endfunction

  // Follow both channels and the register port every cycle.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst) begin
      bucket_count = chs_pkg::CFG_RESET;
      for (int i = 0; i < NBKT; i++) begin
        head_of[i] = NIL;
        size_of[i] = 0;
      end
      for (int i = 0; i < NSLOT; i++) begin
        key_of[i] = '0;
        link_of[i] = 7'(i + 1);
      end
      free_slot = 0;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) bucket_count = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        answers_due.push_back(apply_request(s_axis_tuser, s_axis_tdata[30:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.bucket = m_axis_tdata[5:2];
        got.size = m_axis_tdata[12:6];
        if (answers_due.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.bucket !== want.bucket)
            report($sformatf("bucket %0d, expected %0d", got.bucket, want.bucket));
          if (got.size !== want.size)
            report($sformatf("bucket size %0d, expected %0d", got.size, want.size));
        end
      end
    end
    pending = answers_due.size();
  end
endmodule

@@ tb/chained_hash_set_tb.sv @@
`timescale 1ns / 1ps
module chained_hash_set_tb;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [4:0]  cfg_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // key[30:0], zero pad
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;        // status[1:0], bucket[5:2], bucket_size[12:6], pad
  int          fail_count;
  int          pending;
  logic        calm = 0;
  logic        hold_off = 0;
  logic [30:0] recent_keys [8];

  always #1 clk = ~clk;

  chained_hash_set dut (.*);

  chained_hash_set_checker checker_i (.*);

  // Result side: random stalls, none while calm, a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 17);
  end

  task automatic send(input logic [1:0] op, input logic [30:0] key);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, key};
    do @(posedge clk); while (!s_axis_tready);
    recent_keys[$urandom_range(7)] = key;
    if (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_buckets(input logic [4:0] n);
    drain();
    cfg_we <= 1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Mostly keys seen recently so that deletes and searches hit, some fresh.
  function automatic logic [30:0] pick_key(input int span);
    if ($urandom_range(99) < 60) return recent_keys[$urandom_range(7)];
    if ($urandom_range(99) < 10) return 31'($urandom);
    return 31'($urandom_range(span));
  endfunction

  task automatic random_phase(input int count, input int span);
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: op = FUNC_SPARE;
        1, 2, 3, 4, 5, 6, 7, 8: op = chs_pkg::FUNC_INSERT;
        9, 10, 11, 12, 13, 14: op = chs_pkg::FUNC_DELETE;
        default: op = FUNC_SEARCH;
      endcase
      send(op, pick_key(span));
    end
  endtask

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    foreach (recent_keys[i]) recent_keys[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // Directed: extremes, every operation, absent key, spare code, fill to full.
    send(FUNC_SEARCH, 31'd0);
    send(chs_pkg::FUNC_DELETE, 31'h7FFF_FFFF);
    send(chs_pkg::FUNC_INSERT, 31'h7FFF_FFFF);
    send(chs_pkg::FUNC_INSERT, 31'd0);
    send(chs_pkg::FUNC_INSERT, 31'd10);
    send(chs_pkg::FUNC_INSERT, 31'd10);
    send(FUNC_SEARCH, 31'h7FFF_FFFF);
    send(FUNC_SPARE, 31'd10);
    send(chs_pkg::FUNC_DELETE, 31'd10);
    send(chs_pkg::FUNC_DELETE, 31'd0);
    send(chs_pkg::FUNC_DELETE, 31'd0);
    send(FUNC_SEARCH, 31'h5555_5555);
    send(FUNC_SEARCH, 31'h2AAA_AAAA);
    // Zero bucket count acts as one; fill the pool past full meanwhile.
    set_buckets(5'd0);
    for (int i = 0; i < 64; i++) send(chs_pkg::FUNC_INSERT, 31'($urandom));
    send(chs_pkg::FUNC_INSERT, 31'd7);
    send(chs_pkg::FUNC_DELETE, 31'd7);
    // Pause until every result is back, then hold the receiver off.
    drain();
    hold_off <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      random_phase(6, 40);
    join
    random_phase(200, 40);
    set_buckets(5'd31);
    random_phase(300, 100);
    set_buckets(5'd16);
    random_phase(300, 60);
    set_buckets(5'd1);
    random_phase(200, 20);
    set_buckets(5'd7);
    calm <= 1;
    random_phase(300, 50);
    calm <= 0;
    set_buckets(5'd3);
    random_phase(400, 30);
    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
